/* src/kpclk_pkg.sv */
// Package for the keypad-set minutes:seconds clock.
// Holds the key table, the segment font and the entry phase codes; no dependencies.
package kpclk_pkg;

    typedef logic [7:0] t_seg;
    typedef logic [2:0] t_phase;
    typedef logic [3:0] t_digit;

    localparam t_phase PH_MIN_TENS  = 3'd0;
    localparam t_phase PH_MIN_UNITS = 3'd1;
    localparam t_phase PH_SEC_TENS  = 3'd2;
    localparam t_phase PH_SEC_UNITS = 3'd3;
    localparam t_phase PH_RUN       = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    localparam t_seg SEG_DP   = 8'h80;
    localparam t_seg SEG_DARK = 8'h00;

    localparam logic [7:0] TPS_RESET = 8'd50;
    localparam t_digit     TENS_MAX  = 4'd5;
    localparam t_digit     UNITS_MAX = 4'd9;

    // Map a keypad row/column to the digit value printed on the key.
    function automatic t_digit key_value(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] idx;
        idx = {row, col};
        unique case (idx)
            4'd0:  key_value = 4'd1;
            4'd1:  key_value = 4'd4;
            4'd2:  key_value = 4'd7;
            4'd3:  key_value = 4'd14;
            4'd4:  key_value = 4'd2;
            4'd5:  key_value = 4'd5;
            4'd6:  key_value = 4'd8;
            4'd7:  key_value = 4'd0;
            4'd8:  key_value = 4'd3;
            4'd9:  key_value = 4'd6;
            4'd10: key_value = 4'd9;
            4'd11: key_value = 4'd15;
            4'd12: key_value = 4'd10;
            4'd13: key_value = 4'd11;
            4'd14: key_value = 4'd12;
            default: key_value = 4'd13;
        endcase
    endfunction

    // Seven-segment font, segments a..g on bits 0..6.
    function automatic t_seg seg_font(input t_digit d);
        unique case (d)
            4'd0: seg_font = 8'h3F;
            4'd1: seg_font = 8'h06;
            4'd2: seg_font = 8'h5B;
            4'd3: seg_font = 8'h4F;
            4'd4: seg_font = 8'h66;
            4'd5: seg_font = 8'h6D;
            4'd6: seg_font = 8'h7D;
            4'd7: seg_font = 8'h07;
            4'd8: seg_font = 8'h7F;
            4'd9: seg_font = 8'h67;
            default: seg_font = 8'h3F;
        endcase
    endfunction

endpackage

/* src/kpclk_if.sv */
// Channel interfaces for the keypad-set clock: input items, results, configuration.
// Depends on kpclk_pkg for the segment type.
interface kpclk_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [1:0] key_row;
    logic [1:0] key_col;
    modport source (output valid, op, key_row, key_col, input ready);
    modport sink   (input valid, op, key_row, key_col, output ready);
endinterface

interface kpclk_out_if;
    logic                 valid;
    logic                 ready;
    kpclk_pkg::t_seg      seg_min_tens;
    kpclk_pkg::t_seg      seg_min_units;
    kpclk_pkg::t_seg      seg_sec_tens;
    kpclk_pkg::t_seg      seg_sec_units;
    logic                 running;
    logic                 key_taken;
    modport source (output valid, seg_min_tens, seg_min_units, seg_sec_tens, seg_sec_units,
                    running, key_taken, input ready);
    modport sink   (input valid, seg_min_tens, seg_min_units, seg_sec_tens, seg_sec_units,
                    running, key_taken, output ready);
endinterface

interface kpclk_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] ticks_per_second;
    modport source (output valid, ticks_per_second, input ready);
    modport sink   (input valid, ticks_per_second, output ready);
endinterface

/* src/keypad_set_minute_second_clock.sv */
// Top level of the keypad-set minutes:seconds clock with seven-segment outputs.
// Depends on kpclk_pkg and the channel interfaces in kpclk_if.sv.
//
// Usage:
//   i_in  carries one transaction per event: op = 0 for a refresh tick, op = 1 for a key
//         press given as keypad row and column. Every input transaction yields exactly
//         one result transaction on o_out with the four segment patterns, the running
//         flag and key_taken.
//   i_cfg writes ticks_per_second (refresh ticks per counted second; 0 acts as 1).
//         It is always ready; write it only while no transaction is in flight.
//   After reset the block waits for four digits: minute tens, minute units, second
//   tens, second units. Tens keys above 5 and units keys above 9 are dropped. After
//   the fourth digit it counts, wrapping 59:59 to 00:00.
// Pipeline and throughput:
//   A transaction is held in an input register, then the state update and display are
//   computed in one pass into the result register, which drives o_out.valid. One
//   transaction per cycle is sustained while o_out.ready is high; the two registers
//   form the only storage in the path.
// Reset: i_rst_n is synchronous and active low; it clears both valid flags, the time
//   digits, the entry phase and the prescaler, and loads ticks_per_second 50.
// Stall: while o_out.ready is low the result holds, one more transaction is taken
//   into the input register, then i_in.ready drops until the result is taken.
module keypad_set_minute_second_clock (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kpclk_in_if.sink     i_in,
    kpclk_cfg_if.sink    i_cfg,
    kpclk_out_if.source  o_out
);
    import kpclk_pkg::*;

    // Input register
    logic       r_in_valid;
    logic       r_op;
    logic [1:0] r_row;
    logic [1:0] r_col;

    // Clock state
    logic [7:0] r_tps;
    t_phase     r_phase;
    logic [2:0] r_min_tens;
    t_digit     r_min_units;
    logic [2:0] r_sec_tens;
    t_digit     r_sec_units;
    logic [7:0] r_prescale;

    // Result register
    logic       r_out_valid;
    t_seg       r_seg_mt, r_seg_mu, r_seg_st, r_seg_su;
    logic       r_running, r_taken;

    // Next values
    t_phase     n_phase;
    logic [2:0] n_min_tens;
    t_digit     n_min_units;
    logic [2:0] n_sec_tens;
    t_digit     n_sec_units;
    logic [7:0] n_prescale;
    logic       n_taken;
    t_seg       n_seg_mt, n_seg_mu, n_seg_st, n_seg_su;

    logic       advance;
    t_digit     key_v;
    logic       is_tens;
    logic [7:0] limit;
    logic [8:0] next_cnt;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign key_v    = key_value(r_row, r_col);
    assign is_tens  = (r_phase == PH_MIN_TENS) || (r_phase == PH_SEC_TENS);
    assign limit    = (r_tps == 8'd0) ? 8'd1 : r_tps;
    assign next_cnt = {1'b0, r_prescale} + 9'd1;

    // Key entry and second counting
    always_comb begin
        n_phase     = r_phase;
        n_min_tens  = r_min_tens;
        n_min_units = r_min_units;
        n_sec_tens  = r_sec_tens;
        n_sec_units = r_sec_units;
        n_prescale  = r_prescale;
        n_taken     = 1'b0;
        if (r_op == OP_KEY) begin
            if (r_phase < PH_RUN && key_v <= (is_tens ? TENS_MAX : UNITS_MAX)) begin
                n_taken = 1'b1;
                n_phase = r_phase + 3'd1;
                unique case (r_phase)
                    PH_MIN_TENS:  n_min_tens  = key_v[2:0];
                    PH_MIN_UNITS: n_min_units = key_v;
                    PH_SEC_TENS:  n_sec_tens  = key_v[2:0];
                    default:      n_sec_units = key_v;
                endcase
            end
        end else if (r_phase >= PH_RUN) begin
            if (next_cnt >= {1'b0, limit}) begin
                n_prescale = 8'd0;
                // Ripple the second through the four digits
                if (r_sec_units < UNITS_MAX) begin
                    n_sec_units = r_sec_units + 4'd1;
                end else begin
                    n_sec_units = 4'd0;
                    if (r_sec_tens < TENS_MAX[2:0]) begin
                        n_sec_tens = r_sec_tens + 3'd1;
                    end else begin
                        n_sec_tens = 3'd0;
                        if (r_min_units < UNITS_MAX) begin
                            n_min_units = r_min_units + 4'd1;
                        end else begin
                            n_min_units = 4'd0;
                            if (r_min_tens < TENS_MAX[2:0]) begin
                                n_min_tens = r_min_tens + 3'd1;
                            end else begin
                                n_min_tens = 3'd0;
                            end
                        end
                    end
                end
            end else begin
                n_prescale = next_cnt[7:0];
            end
        end
    end

    // Display: entered digits, decimal point on the pending one, dark after it
    function automatic t_seg show(input t_phase ph, input t_phase pos, input t_digit d);
        if (ph >= PH_RUN || pos < ph) begin
            show = seg_font(d);
        end else if (pos == ph) begin
            show = SEG_DP;
        end else begin
            show = SEG_DARK;
        end
    endfunction

    always_comb begin
        n_seg_mt = show(n_phase, PH_MIN_TENS,  {1'b0, n_min_tens});
        n_seg_mu = show(n_phase, PH_MIN_UNITS, n_min_units);
        n_seg_st = show(n_phase, PH_SEC_TENS,  {1'b0, n_sec_tens});
        n_seg_su = show(n_phase, PH_SEC_UNITS, n_sec_units);
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tps       <= TPS_RESET;
            r_phase     <= PH_MIN_TENS;
            r_min_tens  <= 3'd0;
            r_min_units <= 4'd0;
            r_sec_tens  <= 3'd0;
            r_sec_units <= 4'd0;
            r_prescale  <= 8'd0;
        end else begin
            if (i_cfg.valid) begin
                r_tps <= i_cfg.ticks_per_second;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_min_tens  <= n_min_tens;
                r_min_units <= n_min_units;
                r_sec_tens  <= n_sec_tens;
                r_sec_units <= n_sec_units;
                r_prescale  <= n_prescale;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op  <= i_in.op;
            r_row <= i_in.key_row;
            r_col <= i_in.key_col;
        end
        if (advance) begin
            r_seg_mt  <= n_seg_mt;
            r_seg_mu  <= n_seg_mu;
            r_seg_st  <= n_seg_st;
            r_seg_su  <= n_seg_su;
            r_running <= (n_phase >= PH_RUN);
            r_taken   <= n_taken;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.seg_min_tens  = r_seg_mt;
    assign o_out.seg_min_units = r_seg_mu;
    assign o_out.seg_sec_tens  = r_seg_st;
    assign o_out.seg_sec_units = r_seg_su;
    assign o_out.running       = r_running;
    assign o_out.key_taken     = r_taken;

endmodule
